[rtl/xlb_pkg.sv]
// Package for the GF(2) linear basis block: sequencer states and result field widths.
// No dependencies; used by the top level.
package xlb_pkg;

    // Fixed widths of the result fields
    localparam int MAX_XOR_BITS = 60;
    localparam int RANK_BITS    = 6;
    localparam int RANK_MAX     = 63;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_INS,
        ST_MAX,
        ST_DONE
    } t_state;

endpackage

[rtl/xlb_slot_ram.sv]
// Basis slot memory: one write port, one read port with registered read data.
// Per-entry valid flags cleared by reset make unwritten slots read as zero. No dependencies.
module xlb_slot_ram #(
    parameter int DEPTH = 60,
    parameter int WIDTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_ok;

    // Store written entries
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark written entries; reset empties the whole basis at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Register the read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_ok   <= r_valid[i_rd_addr];
        end
    end

    // Empty slots read as zero
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

[rtl/xor_linear_basis.sv]
// GF(2) linear basis, one slot per leading bit, slots held in a one-port-read memory.
// Each transfer walks the slots from the top for the reduction, then again for the maximum; the reduction stops early
// at the first empty slot that matches a set bit. The slot reads are registered.
// A new item is taken only once the last is through; busy stays high through the strobe cycle.
// The result is shown for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset empties the basis and zeroes the rank.
module xor_linear_basis
    import xlb_pkg::*;
#(
    parameter int VECTOR_BITS = 60
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_operation,
    input  logic [VECTOR_BITS-1:0]  i_vector_value,
    output logic                    o_valid,
    output logic                    o_representable,
    output logic                    o_inserted,
    output logic [RANK_BITS-1:0]    o_basis_rank,
    output logic [MAX_XOR_BITS-1:0] o_max_xor
);

    localparam int AW     = $clog2(VECTOR_BITS);
    localparam int RANK_W = $clog2(VECTOR_BITS + 1);

    t_state r_state, n_state;

    logic                   r_op;
    logic [VECTOR_BITS-1:0] r_val;
    logic [AW-1:0]          r_idx;
    logic                   r_iss;
    logic [AW-1:0]          r_pidx;
    logic                   r_pv;
    logic [AW-1:0]          r_slot;
    logic                   r_found;
    logic                   r_repr;
    logic                   r_ins;
    logic [RANK_W-1:0]      r_rank;
    logic [VECTOR_BITS-1:0] r_acc;

    logic                   rd_en;
    logic                   wr_en;
    logic [VECTOR_BITS-1:0] rd_data;
    logic [VECTOR_BITS-1:0] acc_try;
    logic                   red_hit;
    logic                   red_stop;
    logic                   red_end;
    logic                   max_end;

    xlb_slot_ram #(
        .DEPTH (VECTOR_BITS),
        .WIDTH (VECTOR_BITS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_val)
    );

    // Reduction step on the slot that has just been read
    assign red_hit  = r_pv && r_val[r_pidx];
    assign red_stop = red_hit && (rd_data == '0);
    assign red_end  = r_pv && (red_stop || (r_pidx == '0));
    assign max_end  = r_pv && (r_pidx == '0);
    assign acc_try  = r_acc ^ rd_data;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start)  n_state = ST_RED;
            ST_RED:  if (red_end)  n_state = ST_INS;
            ST_INS:                n_state = ST_MAX;
            ST_MAX:  if (max_end)  n_state = ST_DONE;
            ST_DONE:               n_state = ST_IDLE;
            default:               n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_busy  = 1'b1;
        o_valid = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_busy  = 1'b0;
            ST_RED:  rd_en   = r_iss;
            ST_INS:  wr_en   = r_op && r_found;
            ST_MAX:  rd_en   = r_iss;
            ST_DONE: o_valid = 1'b1;
            default: o_busy  = 1'b1;
        endcase
    end

    // State and rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rank  <= '0;
            r_iss   <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_rank <= r_rank + 1'b1;
            end
            // Advance the slot walk; drop in-flight reads when a walk ends
            if ((r_state == ST_IDLE && i_start) || r_state == ST_INS) begin
                r_iss <= 1'b1;
                r_pv  <= 1'b0;
            end else if ((r_state == ST_RED && red_end) || (r_state == ST_MAX && max_end)) begin
                r_iss <= 1'b0;
                r_pv  <= 1'b0;
            end else begin
                r_pv <= rd_en;
                if (rd_en && r_idx == '0) begin
                    r_iss <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
        if (rd_en) begin
            r_idx <= r_idx - 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                // Capture the transfer
                if (i_start) begin
                    r_op    <= i_operation;
                    r_val   <= i_vector_value;
                    r_idx   <= AW'(VECTOR_BITS - 1);
                    r_found <= 1'b0;
                end
            end
            ST_RED: begin
                // Fold in filled slots; hold the empty slot that stops the walk
                if (red_stop) begin
                    r_found <= 1'b1;
                    r_slot  <= r_pidx;
                end else if (red_hit) begin
                    r_val <= r_val ^ rd_data;
                end
            end
            ST_INS: begin
                r_repr <= !r_found;
                r_ins  <= r_op && r_found;
                r_acc  <= '0;
                r_idx  <= AW'(VECTOR_BITS - 1);
            end
            ST_MAX: begin
                // Keep the larger of acc and acc ^ slot
                if (r_pv && (acc_try > r_acc)) begin
                    r_acc <= acc_try;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_representable = r_repr;
    assign o_inserted      = r_ins;

    // Fit internal rank and maximum onto the fixed result widths
    generate
        if (RANK_W > RANK_BITS) begin : g_rank_sat
            assign o_basis_rank = (r_rank > RANK_W'(RANK_MAX)) ? RANK_BITS'(RANK_MAX)
                                                               : r_rank[RANK_BITS-1:0];
        end else begin : g_rank_ext
            assign o_basis_rank = RANK_BITS'(r_rank);
        end
        if (VECTOR_BITS >= MAX_XOR_BITS) begin : g_max_cut
            assign o_max_xor = r_acc[MAX_XOR_BITS-1:0];
        end else begin : g_max_ext
            assign o_max_xor = MAX_XOR_BITS'(r_acc);
        end
    endgenerate

endmodule
